[rtl/core/windowed_core_utilization_top_macros.svh]
// Assertion macros for the windowed core utilization block.
// Used by windowed_core_utilization_top; expects clk and rst_n in scope.
`ifndef WINDOWED_CORE_UTILIZATION_TOP_MACROS_SVH
`define WINDOWED_CORE_UTILIZATION_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define WCU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wcu assertion failed");

// next-cycle implication, disabled while in reset
`define WCU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wcu assertion failed");

`endif

[rtl/core/wcu_pkg.sv]
// Shared types and constants for the windowed core utilization block.
// No dependencies; imported by wcu_div and windowed_core_utilization_top.
`default_nettype none

package wcu_pkg;

    localparam int TICK_W     = 32;             // tick counter / group width
    localparam int SUM_W      = 34;             // sum of four differences
    localparam int PCT_W      = 15;             // Q8 percent
    localparam int NUM_W      = TICK_W + PCT_W; // diff * 25600
    localparam int CORE_W     = 3;
    localparam int NUM_GROUPS = 4;
    localparam int GROUP_W    = 2;

    localparam logic [PCT_W-1:0] PCT_SCALE = 15'd25600; // 100.0 in Q8

    // group slots in a history word
    localparam logic [GROUP_W-1:0] GRP_USER   = 2'd0;
    localparam logic [GROUP_W-1:0] GRP_KERNEL = 2'd1;
    localparam logic [GROUP_W-1:0] GRP_IDLE   = 2'd2;
    localparam logic [GROUP_W-1:0] GRP_OTHER  = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;   // one-cycle pulse, quotient valid
    } wcu_div_stat_t;

endpackage

`default_nettype wire

[rtl/core/wcu_div.sv]
// Radix-2 restoring divider for one Q8 share: quot = floor(num / den).
// Caller guarantees num < den * 2^PCT_W. Depends on wcu_pkg.
`default_nettype none

module wcu_div
    import wcu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_W-1:0]    num,
    input  wire logic [SUM_W-1:0]    den,
    output logic      [PCT_W-1:0]    quot,
    output wcu_div_stat_t            stat
);

    localparam int CNT_W = $clog2(PCT_W);

    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] den_reg;
    logic [PCT_W-1:0] low_reg;
    logic [PCT_W-1:0] quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [SUM_W:0]   rem_shift;
    logic             fits;

    assign rem_shift = {rem_reg, low_reg[PCT_W-1]};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            low_reg  <= '0;
            quot_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // upper part is already below den, so no quotient bits above PCT_W
                rem_reg  <= SUM_W'(num[NUM_W-1:PCT_W]);
                low_reg  <= num[PCT_W-1:0];
                den_reg  <= den;
                quot_reg <= '0;
                cnt_reg  <= CNT_W'(PCT_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? SUM_W'(rem_shift - {1'b0, den_reg}) : rem_shift[SUM_W-1:0];
                low_reg  <= {low_reg[PCT_W-2:0], 1'b0};
                quot_reg <= {quot_reg[PCT_W-2:0], fits};
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

[rtl/core/windowed_core_utilization_top.sv]
// Top level: per-core utilization shares from cumulative tick counters.
// Depends on wcu_pkg, wcu_div and windowed_core_utilization_top_macros.svh.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid / in_ready | core_index, seven 32-bit tick counters
//   out     | out_valid/out_ready | out_core, four Q8 shares, no_progress
//
// A word with a nonzero summed difference goes from accept through the slot and
// history reads, the difference and the sum, then each group in turn on the shared
// one-bit-per-cycle divider. A zero sum skips the divider; an out-of-range core goes
// straight to the output. After reset a clearing pass writes zeros over the whole
// history, one entry a cycle; in_ready stays low meanwhile.
// A stalled out channel holds the finished word; the next input may already be
// accepted and is held at the end of its work until the output register frees.
`default_nettype none
`include "windowed_core_utilization_top_macros.svh"

module windowed_core_utilization_top
    import wcu_pkg::*;
#(
    parameter int MAX_CORES     = 8,
    parameter int HISTORY_DEPTH = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CORE_W-1:0]    core_index,
    input  wire logic [TICK_W-1:0]    user_ticks,
    input  wire logic [TICK_W-1:0]    nice_ticks,
    input  wire logic [TICK_W-1:0]    system_ticks,
    input  wire logic [TICK_W-1:0]    idle_ticks,
    input  wire logic [TICK_W-1:0]    iowait_ticks,
    input  wire logic [TICK_W-1:0]    irq_ticks,
    input  wire logic [TICK_W-1:0]    softirq_ticks,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [CORE_W-1:0]    out_core,
    output logic      [PCT_W-1:0]     user_percent,
    output logic      [PCT_W-1:0]     kernel_percent,
    output logic      [PCT_W-1:0]     idle_percent,
    output logic      [PCT_W-1:0]     other_percent,
    output logic                      no_progress
);

    localparam int HIST_ENTRIES = MAX_CORES * HISTORY_DEPTH;
    localparam int AW           = $clog2(HIST_ENTRIES);
    localparam int SW           = $clog2(HISTORY_DEPTH);
    localparam int CAW          = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int HW           = NUM_GROUPS * TICK_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT,
        S_DIFF,
        S_SUM,
        S_GO,
        S_WAIT,
        S_DONE
    } state_t;

    // memories: grouped history ring per core, and ring write position per core
    logic [HW-1:0] hist_mem [HIST_ENTRIES];
    logic [SW-1:0] slot_mem [MAX_CORES];

    state_t             state_reg;
    logic [AW-1:0]      clear_cnt_reg;
    logic [CORE_W-1:0]  core_reg;
    logic [TICK_W-1:0]  cur_reg  [NUM_GROUPS];
    logic [TICK_W-1:0]  diff_reg [NUM_GROUPS];
    logic [PCT_W-1:0]   pct_reg  [NUM_GROUPS];
    logic [SUM_W-1:0]   sum_reg;
    logic [GROUP_W-1:0] grp_reg;
    logic               np_reg;
    logic [SW-1:0]      slot_rdata_reg;
    logic [HW-1:0]      hist_rdata_reg;

    logic               out_valid_reg;
    logic [CORE_W-1:0]  out_core_reg;
    logic [PCT_W-1:0]   out_pct_reg [NUM_GROUPS];
    logic               out_np_reg;

    logic               in_fire;
    logic               core_ok;
    logic [SW-1:0]      slot_old;
    logic [AW-1:0]      hist_base;
    logic [AW-1:0]      hist_waddr;
    logic [AW-1:0]      hist_raddr;
    logic [HW-1:0]      hist_wdata;
    logic               hist_we;
    logic               slot_we;
    logic [CAW-1:0]     slot_waddr;
    logic [SW-1:0]      slot_wdata;
    logic               out_free;

    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [PCT_W-1:0]   div_quot;
    wcu_div_stat_t      div_stat;

    logic [PCT_W+1:0]   pct_total;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign core_ok  = (32'(core_index) < MAX_CORES);
    assign out_free = !out_valid_reg || out_ready;

    // ring: write at slot, oldest sample sits one past it
    assign slot_old   = (slot_rdata_reg == SW'(HISTORY_DEPTH - 1)) ? '0
                                                                   : slot_rdata_reg + SW'(1);
    assign hist_base  = AW'(32'(core_reg) * 32'(HISTORY_DEPTH));
    assign hist_raddr = hist_base + AW'(slot_old);
    assign hist_waddr = (state_reg == S_CLEAR) ? clear_cnt_reg
                                               : hist_base + AW'(slot_rdata_reg);
    assign hist_wdata = (state_reg == S_CLEAR) ? '0
                                               : {cur_reg[GRP_OTHER], cur_reg[GRP_IDLE],
                                                  cur_reg[GRP_KERNEL], cur_reg[GRP_USER]};
    assign hist_we    = (state_reg == S_CLEAR) || (state_reg == S_SLOT);

    assign slot_we    = ((state_reg == S_CLEAR) && (32'(clear_cnt_reg) < MAX_CORES))
                        || (state_reg == S_SLOT);
    assign slot_waddr = (state_reg == S_CLEAR) ? CAW'(clear_cnt_reg) : CAW'(core_reg);
    assign slot_wdata = (state_reg == S_CLEAR) ? '0 : slot_old;

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (state_reg == S_SLOT)
        begin
            hist_rdata_reg <= hist_mem[hist_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (state_reg == S_IDLE)
        begin
            slot_rdata_reg <= slot_mem[CAW'(core_index)];
        end
    end

    // shared divider, one group at a time
    assign div_start = (state_reg == S_GO) && (sum_reg != '0);
    assign div_num   = NUM_W'(diff_reg[grp_reg]) * NUM_W'(PCT_SCALE);

    wcu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (sum_reg),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clear_cnt_reg <= '0;
            core_reg      <= '0;
            cur_reg       <= '{default: '0};
            diff_reg      <= '{default: '0};
            pct_reg       <= '{default: '0};
            sum_reg       <= '0;
            grp_reg       <= '0;
            np_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
            out_core_reg  <= '0;
            out_pct_reg   <= '{default: '0};
            out_np_reg    <= 1'b0;
        end
        else
        begin
            // in S_DONE the output register is reloaded below instead
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    if (clear_cnt_reg == AW'(HIST_ENTRIES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        clear_cnt_reg <= clear_cnt_reg + AW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        core_reg            <= core_index;
                        cur_reg[GRP_USER]   <= user_ticks + nice_ticks;
                        cur_reg[GRP_KERNEL] <= system_ticks;
                        cur_reg[GRP_IDLE]   <= idle_ticks;
                        cur_reg[GRP_OTHER]  <= iowait_ticks + irq_ticks + softirq_ticks;
                        pct_reg             <= '{default: '0};
                        np_reg              <= 1'b1;
                        grp_reg             <= '0;
                        // core beyond the table: no state touched
                        state_reg           <= core_ok ? S_SLOT : S_DONE;
                    end
                end
                S_SLOT:
                begin
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    for (int g = 0; g < NUM_GROUPS; g++)
                    begin
                        diff_reg[g] <= cur_reg[g] - hist_rdata_reg[g*TICK_W +: TICK_W];
                    end
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    sum_reg   <= SUM_W'(diff_reg[GRP_USER]) + SUM_W'(diff_reg[GRP_KERNEL])
                               + SUM_W'(diff_reg[GRP_IDLE]) + SUM_W'(diff_reg[GRP_OTHER]);
                    state_reg <= S_GO;
                end
                S_GO:
                begin
                    if (sum_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        np_reg    <= 1'b0;
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        pct_reg[grp_reg] <= div_quot;
                        if (grp_reg == GROUP_W'(NUM_GROUPS - 1))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            grp_reg   <= grp_reg + GROUP_W'(1);
                            state_reg <= S_GO;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_core_reg  <= core_reg;
                        out_pct_reg   <= pct_reg;
                        out_np_reg    <= np_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_core       = out_core_reg;
    assign user_percent   = out_pct_reg[GRP_USER];
    assign kernel_percent = out_pct_reg[GRP_KERNEL];
    assign idle_percent   = out_pct_reg[GRP_IDLE];
    assign other_percent  = out_pct_reg[GRP_OTHER];
    assign no_progress    = out_np_reg;

    assign pct_total = (PCT_W+2)'(user_percent) + (PCT_W+2)'(kernel_percent)
                     + (PCT_W+2)'(idle_percent) + (PCT_W+2)'(other_percent);

    // one word in flight: nothing accepted right after an accept
    `WCU_ASSERT_NEXT(a_one_in_flight, in_fire, !in_ready)
    // a flagged word carries only zero shares
    `WCU_ASSERT_SAME(a_np_zero, out_valid && no_progress, pct_total == '0)
    // truncated shares add up to 100% less at most one LSB per group
    `WCU_ASSERT_SAME(a_share_total, out_valid && !no_progress,
                     (pct_total <= 17'd25600) && (pct_total >= 17'd25597))

endmodule

`default_nettype wire

[tb/sv/windowed_core_utilization_checker.sv]
`timescale 1ns / 1ps
// Checker for windowed_core_utilization_top: watches both word channels, keeps its own
// per-core rings of grouped samples and compares every result word with its prediction.
// Depends on wcu_pkg.
module windowed_core_utilization_checker
    import wcu_pkg::*;
#(
    parameter int MAX_CORES     = 8,
    parameter int HISTORY_DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [CORE_W-1:0]   core_index,
    input  logic [TICK_W-1:0]   user_ticks,
    input  logic [TICK_W-1:0]   nice_ticks,
    input  logic [TICK_W-1:0]   system_ticks,
    input  logic [TICK_W-1:0]   idle_ticks,
    input  logic [TICK_W-1:0]   iowait_ticks,
    input  logic [TICK_W-1:0]   irq_ticks,
    input  logic [TICK_W-1:0]   softirq_ticks,

    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [CORE_W-1:0]   out_core,
    input  logic [PCT_W-1:0]    user_percent,
    input  logic [PCT_W-1:0]    kernel_percent,
    input  logic [PCT_W-1:0]    idle_percent,
    input  logic [PCT_W-1:0]    other_percent,
    input  logic                no_progress,

    output int                  fail_count,
    output int                  pending,
    output int                  checked,
    output int                  stalled_count
);

    typedef struct packed {
        logic [TICK_W-1:0] user;
        logic [TICK_W-1:0] kernel;
        logic [TICK_W-1:0] idle;
        logic [TICK_W-1:0] other;
    } group_sample_t;

    typedef struct packed {
        logic [CORE_W-1:0] core;
        logic [PCT_W-1:0]  user;
        logic [PCT_W-1:0]  kernel;
        logic [PCT_W-1:0]  idle;
        logic [PCT_W-1:0]  other;
        logic              no_progress;
    } share_word_t;

    group_sample_t sample_ring [MAX_CORES][HISTORY_DEPTH];
    int unsigned   write_pos   [MAX_CORES];
    share_word_t   expected_shares [$];

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // truncated Q8 percentage; total is never zero here and never below part
    function automatic logic [PCT_W-1:0] q8_share(input logic [TICK_W-1:0] part,
                                                  input logic [SUM_W-1:0] total);
        logic [63:0] scaled;
        scaled = 64'(part) * 64'(PCT_SCALE);
        return PCT_W'(scaled / 64'(total));
    endfunction

    task automatic predict_shares(input logic [CORE_W-1:0] core, input group_sample_t cur);
        int unsigned   slot;
        int unsigned   oldest;
        group_sample_t prev;
        group_sample_t delta;
        logic [SUM_W-1:0] total;
        share_word_t   w;
        w = '0;
        w.core = core;
        w.no_progress = 1'b1;
        if (int'(core) < MAX_CORES)
        begin
            slot   = write_pos[core] % HISTORY_DEPTH;
            oldest = (slot + 1) % HISTORY_DEPTH;
            prev   = sample_ring[core][oldest];
            // differences wrap at 32 bits
            delta.user   = cur.user   - prev.user;
            delta.kernel = cur.kernel - prev.kernel;
            delta.idle   = cur.idle   - prev.idle;
            delta.other  = cur.other  - prev.other;
            sample_ring[core][slot] = cur;
            write_pos[core] = oldest;
            // full-width sum, no wrap
            total = SUM_W'(delta.user) + SUM_W'(delta.kernel)
                  + SUM_W'(delta.idle) + SUM_W'(delta.other);
            if (total != '0)
            begin
                w.user   = q8_share(delta.user, total);
                w.kernel = q8_share(delta.kernel, total);
                w.idle   = q8_share(delta.idle, total);
                w.other  = q8_share(delta.other, total);
                w.no_progress = 1'b0;
            end
        end
        expected_shares.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        group_sample_t cur;
        share_word_t   want;
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CORES; c++)
            begin
                write_pos[c] = 0;
                for (int d = 0; d < HISTORY_DEPTH; d++)
                    sample_ring[c][d] = '0;
            end
            expected_shares.delete();
            fail_count    = 0;
            pending       = 0;
            checked       = 0;
            stalled_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_shares.size() == 0)
                    report($sformatf("result word for core %0d with nothing expected",
                                     out_core));
                else
                begin
                    want = expected_shares.pop_front();
                    check_field("out_core", out_core, want.core);
                    check_field("user_percent", user_percent, want.user);
                    check_field("kernel_percent", kernel_percent, want.kernel);
                    check_field("idle_percent", idle_percent, want.idle);
                    check_field("other_percent", other_percent, want.other);
                    check_field("no_progress", no_progress, want.no_progress);
                    checked++;
                    if (want.no_progress)
                        stalled_count++;
                end
            end
            if (in_valid && in_ready)
            begin
                cur.user   = user_ticks + nice_ticks;
                cur.kernel = system_ticks;
                cur.idle   = idle_ticks;
                cur.other  = iowait_ticks + irq_ticks + softirq_ticks;
                predict_shares(core_index, cur);
            end
            pending = expected_shares.size();
        end
    end

endmodule

[tb/sv/windowed_core_utilization_top_test.sv]
`timescale 1ns / 1ps
// Testbench top for windowed_core_utilization_top: drives tick-counter words, stalls the
// result channel and gives the verdict. Depends on wcu_pkg and the checker module.
module windowed_core_utilization_top_test;
    import wcu_pkg::*;

    localparam int MAX_CORES        = 8;
    localparam int HISTORY_DEPTH    = 4;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int NUM_PHASES       = 5;
    localparam int HOLD_OFF_CYCLES  = 500;
    localparam int QUIET_LIMIT      = 3000;
    localparam int DRAIN_CYCLES     = 100;

    typedef struct packed {
        logic [TICK_W-1:0] user;
        logic [TICK_W-1:0] nice;
        logic [TICK_W-1:0] system;
        logic [TICK_W-1:0] idle;
        logic [TICK_W-1:0] iowait;
        logic [TICK_W-1:0] irq;
        logic [TICK_W-1:0] softirq;
    } tick_sample_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [CORE_W-1:0]  core_index;
    logic [TICK_W-1:0]  user_ticks;
    logic [TICK_W-1:0]  nice_ticks;
    logic [TICK_W-1:0]  system_ticks;
    logic [TICK_W-1:0]  idle_ticks;
    logic [TICK_W-1:0]  iowait_ticks;
    logic [TICK_W-1:0]  irq_ticks;
    logic [TICK_W-1:0]  softirq_ticks;
    logic               out_valid;
    logic               out_ready;
    logic [CORE_W-1:0]  out_core;
    logic [PCT_W-1:0]   user_percent;
    logic [PCT_W-1:0]   kernel_percent;
    logic [PCT_W-1:0]   idle_percent;
    logic [PCT_W-1:0]   other_percent;
    logic               no_progress;

    int fail_count;
    int pending;
    int checked;
    int stalled_count;

    tick_sample_t counters [MAX_CORES];
    int idle_pct;
    int stall_pct;
    int hold_asked;
    int sent;
    int quiet_cycles;

    windowed_core_utilization_top #(
        .MAX_CORES     (MAX_CORES),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .core_index     (core_index),
        .user_ticks     (user_ticks),
        .nice_ticks     (nice_ticks),
        .system_ticks   (system_ticks),
        .idle_ticks     (idle_ticks),
        .iowait_ticks   (iowait_ticks),
        .irq_ticks      (irq_ticks),
        .softirq_ticks  (softirq_ticks),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_core       (out_core),
        .user_percent   (user_percent),
        .kernel_percent (kernel_percent),
        .idle_percent   (idle_percent),
        .other_percent  (other_percent),
        .no_progress    (no_progress)
    );

    windowed_core_utilization_checker #(
        .MAX_CORES     (MAX_CORES),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) util_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .core_index     (core_index),
        .user_ticks     (user_ticks),
        .nice_ticks     (nice_ticks),
        .system_ticks   (system_ticks),
        .idle_ticks     (idle_ticks),
        .iowait_ticks   (iowait_ticks),
        .irq_ticks      (irq_ticks),
        .softirq_ticks  (softirq_ticks),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_core       (out_core),
        .user_percent   (user_percent),
        .kernel_percent (kernel_percent),
        .idle_percent   (idle_percent),
        .other_percent  (other_percent),
        .no_progress    (no_progress),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked),
        .stalled_count  (stalled_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // one counter step: mostly modest, sometimes frozen, now and then a wrap
    function automatic logic [TICK_W-1:0] advance(input logic [TICK_W-1:0] v);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15)
            return v;
        else if (r < 85)
            return v + $urandom_range(2000);
        else if (r < 95)
            return v + $urandom_range(1 << 20);
        else
            return v + $urandom;
    endfunction

    // present one word at a falling edge and hold it until accepted
    task automatic offer(input logic [CORE_W-1:0] core, input tick_sample_t s);
        if (idle_pct > 0)
        begin
            if ($urandom_range(9) == 0)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 90)) @(negedge clk);
            end
            while ($urandom_range(99) < idle_pct)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        core_index    = core;
        user_ticks    = s.user;
        nice_ticks    = s.nice;
        system_ticks  = s.system;
        idle_ticks    = s.idle;
        iowait_ticks  = s.iowait;
        irq_ticks     = s.irq;
        softirq_ticks = s.softirq;
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        counters[core] = s;
        sent++;
    endtask

    task automatic random_word();
        int unsigned  r;
        logic [CORE_W-1:0] core;
        tick_sample_t s;
        r    = $urandom_range(99);
        core = CORE_W'($urandom_range(MAX_CORES - 1));
        s    = counters[core];
        if (r < 80)
        begin
            s.user    = advance(s.user);
            s.nice    = advance(s.nice);
            s.system  = advance(s.system);
            s.idle    = advance(s.idle);
            s.iowait  = advance(s.iowait);
            s.irq     = advance(s.irq);
            s.softirq = advance(s.softirq);
            offer(core, s);
        end
        else if (r < 88)
        begin
            // core stops counting: the last word of the burst sees no progress
            repeat (HISTORY_DEPTH) offer(core, s);
        end
        else
        begin
            s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            offer(core, s);
        end
    endtask

    // result side; a long hold-off is counted here once requested
    initial
    begin
        int hold_left;
        int hold_done;
        hold_left = 0;
        hold_done = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_done)
            begin
                hold_done = hold_asked;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, pending);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        tick_sample_t s;
        int target;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        core_index    = '0;
        user_ticks    = '0;
        nice_ticks    = '0;
        system_ticks  = '0;
        idle_ticks    = '0;
        iowait_ticks  = '0;
        irq_ticks     = '0;
        softirq_ticks = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_asked    = 0;
        sent          = 0;
        quiet_cycles  = 0;
        for (int c = 0; c < MAX_CORES; c++)
            counters[c] = '0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // first sample of all zeros against a zero history: nothing moved
        offer(0, '0);
        // every counter at full scale: group sums wrap
        offer(1, '1);
        s = '0;
        s.user = 1;
        offer(2, s);
        s = '0;
        s.idle = 1;
        offer(5, s);
        s = '0;
        s.system = 32'h0000_0007;
        offer(6, s);
        s = '0;
        s.iowait  = 32'h8000_0000;
        s.irq     = 32'h8000_0000;
        s.softirq = 32'h0000_0003;
        offer(6, s);
        s = '0;
        s.user = '1;
        offer(7, s);
        // same sample four times: the last compares against itself
        s = '{user: 100, nice: 50, system: 70, idle: 900, iowait: 5, irq: 3, softirq: 2};
        repeat (HISTORY_DEPTH) offer(3, s);
        // counters fall back below the compared sample: differences wrap
        s = {7{32'hF000_0000}};
        offer(4, s);
        s = {7{32'h0000_0010}};
        repeat (HISTORY_DEPTH - 1) offer(4, s);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                3: begin idle_pct = 23; stall_pct = 23; end
                default:
                begin
                    // output held while words keep coming: input side must back up
                    idle_pct  = 0;
                    stall_pct = 10;
                    hold_asked++;
                end
            endcase
            target = sent + RANDOM_PER_PHASE;
            while (sent < target)
                random_word();
        end
        in_valid = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d samples on %0d cores: directed edges, frozen and random %s",
                 sent, MAX_CORES, "words, four idle mixes and a long output hold-off");
        $display("%0d result words compared, %0d with no progress, %0d mismatches",
                 checked, stalled_count, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/wcu_pkg.sv
rtl/core/wcu_div.sv
rtl/core/windowed_core_utilization_top.sv
tb/sv/windowed_core_utilization_checker.sv
tb/sv/windowed_core_utilization_top_test.sv
